// File: src/pixel_format_unpacker_assert.svh
// Assertion macros for the checker file of the pixel unpacker.
// Each macro expects a clock named clk in the enclosing scope.
`ifndef PIXEL_FORMAT_UNPACKER_ASSERT_SVH
`define PIXEL_FORMAT_UNPACKER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PFU_ASSERT_SAME(lbl, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PFU_ASSERT_NEXT(lbl, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst)) (ante) |=> (cons)) \
    else $error(msg);

// What must hold in the cycle after reset is seen.
`define PFU_ASSERT_RESET(lbl, rst, cons, msg) \
  lbl: assert property (@(posedge clk) !(rst) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pfu_pkg.sv
`default_nettype none
package pfu_pkg;

  localparam int DATA_W      = 8;
  localparam int COLOR_W     = 32;
  localparam int PIX_W       = 32;
  localparam int FMT_W       = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int HEIGHT_W    = 13;
  localparam int ROW_W       = 12;
  localparam int PAL_SIZE_W  = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int WIDTH_CMP_W = 17;
  localparam int HEIGHT_MAX  = 4096;

  localparam logic [FMT_W-1:0] FMT_RGB8       = 4'd0;
  localparam logic [FMT_W-1:0] FMT_RGB16      = 4'd1;
  localparam logic [FMT_W-1:0] FMT_RGBA8      = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA16     = 4'd3;
  localparam logic [FMT_W-1:0] FMT_LUM1       = 4'd4;
  localparam logic [FMT_W-1:0] FMT_LUM2       = 4'd5;
  localparam logic [FMT_W-1:0] FMT_LUM4       = 4'd6;
  localparam logic [FMT_W-1:0] FMT_LUM8       = 4'd7;
  localparam logic [FMT_W-1:0] FMT_LUM16      = 4'd8;
  localparam logic [FMT_W-1:0] FMT_LUMALPHA8  = 4'd9;
  localparam logic [FMT_W-1:0] FMT_LUMALPHA16 = 4'd10;
  localparam logic [FMT_W-1:0] FMT_INDEX1     = 4'd11;
  localparam logic [FMT_W-1:0] FMT_INDEX2     = 4'd12;
  localparam logic [FMT_W-1:0] FMT_INDEX4     = 4'd13;
  localparam logic [FMT_W-1:0] FMT_INDEX8     = 4'd14;

  localparam logic [CFG_IDX_W-1:0] CFG_FORMAT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORDER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAL_SIZE = 3'd4;

  // Sub-byte sample width codes.
  localparam logic [1:0] BPP_1 = 2'd0;
  localparam logic [1:0] BPP_2 = 2'd1;
  localparam logic [1:0] BPP_4 = 2'd2;

  typedef struct packed {
    logic [FMT_W-1:0]      fmt;
    logic                  order;
    logic [HEIGHT_W-1:0]   height;
    logic [PAL_SIZE_W-1:0] pal_size;
  } cfg_t;

  typedef struct packed {
    logic             pal_sel;
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             row_end;
    logic             frame_end;
  } res_t;

  // Channels per pixel for the byte-aligned direct formats.
  function automatic logic [2:0] chan_count(input logic [FMT_W-1:0] fmt);
    logic [2:0] n;
    unique case (fmt)
      FMT_RGB8, FMT_RGB16:            n = 3'd3;
      FMT_RGBA8, FMT_RGBA16:          n = 3'd4;
      FMT_LUM8, FMT_LUM16:            n = 3'd1;
      FMT_LUMALPHA8, FMT_LUMALPHA16:  n = 3'd2;
      default:                        n = 3'd0;
    endcase
    return n;
  endfunction

  // Bytes per channel for the byte-aligned direct formats.
  function automatic logic [1:0] chan_stride(input logic [FMT_W-1:0] fmt);
    logic [1:0] s;
    unique case (fmt)
      FMT_RGB16, FMT_RGBA16, FMT_LUM16, FMT_LUMALPHA16: s = 2'd2;
      default:                                          s = 2'd1;
    endcase
    return s;
  endfunction

  function automatic logic [PIX_W-1:0] pack_pixel(input logic order,
                                                  input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b,
                                                  input logic [7:0] a);
    return order ? {a, r, g, b} : {a, b, g, r};
  endfunction

endpackage
`default_nettype wire

// File: src/pixel_format_unpacker.sv
// An accepted byte is registered in the input stage, each pixel in the output stage.
// Throughput: one byte-aligned format byte or palette write per cycle, a sub-byte
// byte's pixels (up to 8) one per cycle on the one pixel path, unless output stalls.
// Reset: synchronous, active low; clears configuration, image position and valid
// flags. Palette contents are not cleared.
`default_nettype none
module pixel_format_unpacker #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] data_byte, [15:8] palette_index, [47:16] palette_color
  input  logic [pfu_pkg::IN_TDATA_W-1:0] in_tdata,
  // [0] kind
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] pixel
  output logic [pfu_pkg::PIX_W-1:0]      out_tdata,
  output logic                           out_tlast,
  // [0] row_end, [1] frame_end
  output logic [1:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [pfu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pfu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int AW = $clog2(PALETTE_DEPTH);

  pfu_pkg::cfg_t               cfg;
  logic [CW:0]                 width_eff;
  logic                        restart;
  logic                        adv;
  logic                        fire;
  pfu_pkg::res_t               res;
  logic                        pal_we;
  logic [AW-1:0]               pal_waddr;
  logic [pfu_pkg::COLOR_W-1:0] pal_wdata;
  logic [AW-1:0]               pal_raddr;
  logic [pfu_pkg::COLOR_W-1:0] pal_rdata;

  assign cfg_ready = 1'b1;

  pfu_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .cfg       (cfg),
    .width_eff (width_eff),
    .restart   (restart)
  );

  pfu_unpack #(.MAX_WIDTH(MAX_WIDTH), .PALETTE_DEPTH(PALETTE_DEPTH)) u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .width_eff (width_eff),
    .restart   (restart),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_byte   (in_tdata[7:0]),
    .in_idx    (in_tdata[15:8]),
    .in_color  (in_tdata[47:16]),
    .adv       (adv),
    .fire      (fire),
    .res       (res),
    .pal_we    (pal_we),
    .pal_waddr (pal_waddr),
    .pal_wdata (pal_wdata),
    .pal_raddr (pal_raddr)
  );

  pfu_pal #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_pal (
    .clk   (clk),
    .we    (pal_we),
    .waddr (pal_waddr),
    .wdata (pal_wdata),
    .re    (fire),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  pfu_out u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (fire),
    .res_in        (res),
    .order         (cfg.order),
    .pal_data      (pal_rdata),
    .out_ready     (out_tready),
    .out_valid     (out_tvalid),
    .out_pixel     (out_tdata),
    .out_last      (out_tlast),
    .out_row_end   (out_tuser[0]),
    .out_frame_end (out_tuser[1]),
    .free          (adv)
  );

endmodule
`default_nettype wire

// File: src/pfu_cfg.sv
`default_nettype none
module pfu_cfg #(
  parameter int MAX_WIDTH = 4096,
  localparam int WIDTH_W  = $clog2(MAX_WIDTH) + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [pfu_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [pfu_pkg::CFG_DATA_W-1:0] wr_data,
  output pfu_pkg::cfg_t                  cfg,
  output logic [WIDTH_W-1:0]             width_eff,
  output logic                           restart
);

  pfu_pkg::cfg_t                     cfg_r;
  logic [WIDTH_W-1:0]                width_r;
  logic [pfu_pkg::WIDTH_CMP_W-1:0]   w_ext;
  logic [pfu_pkg::WIDTH_CMP_W-1:0]   w_clamp;
  logic [pfu_pkg::HEIGHT_W-1:0]      h_clamp;

  // Width and height are stored already clamped to their legal range.
  always_comb begin
    w_ext = pfu_pkg::WIDTH_CMP_W'(wr_data);
    if (w_ext == '0) begin
      w_clamp = pfu_pkg::WIDTH_CMP_W'(1);
    end else if (w_ext > pfu_pkg::WIDTH_CMP_W'(MAX_WIDTH)) begin
      w_clamp = pfu_pkg::WIDTH_CMP_W'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    if (wr_data == '0) begin
      h_clamp = pfu_pkg::HEIGHT_W'(1);
    end else if (wr_data > pfu_pkg::HEIGHT_W'(pfu_pkg::HEIGHT_MAX)) begin
      h_clamp = pfu_pkg::HEIGHT_W'(pfu_pkg::HEIGHT_MAX);
    end else begin
      h_clamp = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fmt      <= pfu_pkg::FMT_RGB8;
      cfg_r.order    <= 1'b0;
      cfg_r.height   <= pfu_pkg::HEIGHT_W'(1);
      cfg_r.pal_size <= '0;
      width_r        <= WIDTH_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        pfu_pkg::CFG_FORMAT:   cfg_r.fmt      <= wr_data[pfu_pkg::FMT_W-1:0];
        pfu_pkg::CFG_ORDER:    cfg_r.order    <= wr_data[0];
        pfu_pkg::CFG_WIDTH:    width_r        <= w_clamp[WIDTH_W-1:0];
        pfu_pkg::CFG_HEIGHT:   cfg_r.height   <= h_clamp;
        pfu_pkg::CFG_PAL_SIZE: cfg_r.pal_size <= wr_data[pfu_pkg::PAL_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg       = cfg_r;
  assign width_eff = width_r;
  assign restart   = wr_en && (wr_index == pfu_pkg::CFG_FORMAT ||
                               wr_index == pfu_pkg::CFG_WIDTH  ||
                               wr_index == pfu_pkg::CFG_HEIGHT);

endmodule
`default_nettype wire

// File: src/pfu_pal.sv
`default_nettype none
module pfu_pal #(
  parameter int PALETTE_DEPTH = 256,
  localparam int AW           = $clog2(PALETTE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pfu_pkg::COLOR_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pfu_pkg::COLOR_W-1:0] rdata
);

  logic [pfu_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [pfu_pkg::COLOR_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data only moves when a pixel is loaded, so it holds under a stall.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/pfu_unpack.sv
`default_nettype none
module pfu_unpack #(
  parameter int MAX_WIDTH     = 4096,
  parameter int PALETTE_DEPTH = 256,
  localparam int CW           = $clog2(MAX_WIDTH),
  localparam int AW           = $clog2(PALETTE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pfu_pkg::cfg_t               cfg,
  input  logic [CW:0]                 width_eff,
  input  logic                        restart,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_kind,
  input  logic [pfu_pkg::DATA_W-1:0]  in_byte,
  input  logic [pfu_pkg::DATA_W-1:0]  in_idx,
  input  logic [pfu_pkg::COLOR_W-1:0] in_color,
  input  logic                        adv,
  output logic                        fire,
  output pfu_pkg::res_t               res,
  output logic                        pal_we,
  output logic [AW-1:0]               pal_waddr,
  output logic [pfu_pkg::COLOR_W-1:0] pal_wdata,
  output logic [AW-1:0]               pal_raddr
);

  logic                          s1_valid_r;
  logic                          s1_kind_r;
  logic [pfu_pkg::DATA_W-1:0]    s1_byte_r;
  logic [pfu_pkg::DATA_W-1:0]    s1_idx_r;
  logic [pfu_pkg::COLOR_W-1:0]   s1_color_r;
  logic [2:0]                    s1_sub_r;
  logic [2:0]                    phase_r;
  logic [23:0]                   held_r;
  logic [23:0]                   held_nxt;
  logic [CW-1:0]                 col_r;
  logic [pfu_pkg::ROW_W-1:0]     row_r;

  logic                          is_sub;
  logic                          sub_pal;
  logic [1:0]                    bpp;
  logic                          is_idx8;
  logic                          is_multi;
  logic [7:0]                    sub_v;
  logic [7:0]                    sub_lum;
  logic                          sub_last;
  logic [pfu_pkg::DATA_W-1:0]    byte_shift;
  logic [7:0]                    idx_v;
  logic                          pal_ok;

  logic [CW:0]                   col_inc;
  logic [pfu_pkg::HEIGHT_W-1:0]  row_inc;
  logic                          row_end_now;
  logic                          frame_end_now;

  logic [2:0]                    ch;
  logic [1:0]                    st;
  logic                          on_chan;
  logic [2:0]                    chan_idx;
  logic [3:0]                    chan_inc;
  logic [3:0]                    total;
  logic [3:0]                    ph_inc;
  logic [2:0]                    ph_nxt;
  logic                          multi_emit;
  logic                          multi_hold;
  logic [pfu_pkg::PIX_W-1:0]     multi_pix;

  logic                          emit_want;
  logic                          step_last;
  logic                          retire;
  logic                          accept;
  logic                          out_pal_sel;
  logic [pfu_pkg::PIX_W-1:0]     out_pix;

  // Format decode.
  always_comb begin
    is_sub  = 1'b0;
    sub_pal = 1'b0;
    bpp     = pfu_pkg::BPP_1;
    unique case (cfg.fmt)
      pfu_pkg::FMT_LUM1:   begin is_sub = 1'b1; bpp = pfu_pkg::BPP_1; end
      pfu_pkg::FMT_LUM2:   begin is_sub = 1'b1; bpp = pfu_pkg::BPP_2; end
      pfu_pkg::FMT_LUM4:   begin is_sub = 1'b1; bpp = pfu_pkg::BPP_4; end
      pfu_pkg::FMT_INDEX1: begin is_sub = 1'b1; sub_pal = 1'b1; bpp = pfu_pkg::BPP_1; end
      pfu_pkg::FMT_INDEX2: begin is_sub = 1'b1; sub_pal = 1'b1; bpp = pfu_pkg::BPP_2; end
      pfu_pkg::FMT_INDEX4: begin is_sub = 1'b1; sub_pal = 1'b1; bpp = pfu_pkg::BPP_4; end
      default: ;
    endcase
    is_idx8  = (cfg.fmt == pfu_pkg::FMT_INDEX8);
    ch       = pfu_pkg::chan_count(cfg.fmt);
    st       = pfu_pkg::chan_stride(cfg.fmt);
    is_multi = (ch != 3'd0);
  end

  // Sub-byte samples come from the top of a byte that shifts left as pixels
  // leave. Luminance expansion by 255, 85 or 17 is a bit replication.
  always_comb begin
    unique case (bpp)
      pfu_pkg::BPP_1: begin
        sub_v      = {7'b0, s1_byte_r[7]};
        sub_lum    = {8{s1_byte_r[7]}};
        sub_last   = (s1_sub_r == 3'd7);
        byte_shift = {s1_byte_r[6:0], 1'b0};
      end
      pfu_pkg::BPP_2: begin
        sub_v      = {6'b0, s1_byte_r[7:6]};
        sub_lum    = {4{s1_byte_r[7:6]}};
        sub_last   = (s1_sub_r == 3'd3);
        byte_shift = {s1_byte_r[5:0], 2'b0};
      end
      default: begin
        sub_v      = {4'b0, s1_byte_r[7:4]};
        sub_lum    = {2{s1_byte_r[7:4]}};
        sub_last   = (s1_sub_r == 3'd1);
        byte_shift = {s1_byte_r[3:0], 4'b0};
      end
    endcase
    idx_v  = is_idx8 ? s1_byte_r : sub_v;
    pal_ok = ({1'b0, idx_v} < cfg.pal_size) &&
             ({1'b0, idx_v} < pfu_pkg::PAL_SIZE_W'(PALETTE_DEPTH));
  end

  // Image position of the pixel that would leave now.
  always_comb begin
    col_inc       = {1'b0, col_r} + {{CW{1'b0}}, 1'b1};
    row_inc       = {1'b0, row_r} + pfu_pkg::HEIGHT_W'(1);
    row_end_now   = (col_inc >= width_eff);
    frame_end_now = row_end_now && (row_inc >= cfg.height);
  end

  // Byte-aligned formats: a phase counter walks the bytes of one pixel.
  // In sixteen-bit formats only the first byte of each channel is used.
  always_comb begin
    on_chan    = (st == 2'd1) || !phase_r[0];
    chan_idx   = (st == 2'd2) ? {1'b0, phase_r[2:1]} : phase_r;
    chan_inc   = {1'b0, chan_idx} + 4'd1;
    total      = (st == 2'd2) ? {ch, 1'b0} : {1'b0, ch};
    ph_inc     = {1'b0, phase_r} + 4'd1;
    ph_nxt     = (ph_inc >= total) ? 3'd0 : ph_inc[2:0];
    multi_emit = on_chan && (chan_inc == {1'b0, ch});
    multi_hold = on_chan && (chan_inc < {1'b0, ch});
    held_nxt   = held_r;
    unique case (chan_idx[1:0])
      2'd0:    held_nxt[7:0]   = s1_byte_r;
      2'd1:    held_nxt[15:8]  = s1_byte_r;
      default: held_nxt[23:16] = s1_byte_r;
    endcase
    unique case (ch)
      3'd3: multi_pix = pfu_pkg::pack_pixel(cfg.order, held_r[7:0], held_r[15:8],
                                            s1_byte_r, 8'hFF);
      3'd4: multi_pix = pfu_pkg::pack_pixel(cfg.order, held_r[7:0], held_r[15:8],
                                            held_r[23:16], s1_byte_r);
      3'd1: multi_pix = pfu_pkg::pack_pixel(cfg.order, s1_byte_r, s1_byte_r,
                                            s1_byte_r, 8'hFF);
      default: multi_pix = pfu_pkg::pack_pixel(cfg.order, held_r[7:0], held_r[7:0],
                                               held_r[7:0], s1_byte_r);
    endcase
  end

  always_comb begin
    emit_want   = 1'b0;
    step_last   = 1'b1;
    out_pal_sel = 1'b0;
    out_pix     = '0;
    priority if (s1_kind_r) begin
      emit_want = 1'b0;
    end else if (is_sub) begin
      emit_want = 1'b1;
      // Padding bits after the row's last pixel are dropped.
      step_last = sub_last || row_end_now;
      if (sub_pal) begin
        out_pal_sel = pal_ok;
      end else begin
        out_pix = pfu_pkg::pack_pixel(cfg.order, sub_lum, sub_lum, sub_lum, 8'hFF);
      end
    end else if (is_idx8) begin
      emit_want   = 1'b1;
      out_pal_sel = pal_ok;
    end else if (is_multi) begin
      emit_want = multi_emit;
      out_pix   = multi_pix;
    end else begin
      emit_want = 1'b0;
    end
  end

  assign fire     = s1_valid_r && emit_want && adv;
  assign retire   = s1_valid_r && (!emit_want || (fire && step_last));
  assign in_ready = !s1_valid_r || retire;
  assign accept   = in_valid && in_ready;

  assign res.pal_sel   = out_pal_sel;
  assign res.pixel     = out_pix;
  assign res.last      = step_last;
  assign res.row_end   = row_end_now;
  assign res.frame_end = frame_end_now;

  // Palette writes take effect in stream order, when the item reaches this stage.
  assign pal_we    = s1_valid_r && s1_kind_r &&
                     ({1'b0, s1_idx_r} < pfu_pkg::PAL_SIZE_W'(PALETTE_DEPTH));
  assign pal_waddr = s1_idx_r[AW-1:0];
  assign pal_wdata = s1_color_r;
  assign pal_raddr = idx_v[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (retire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r  <= in_kind;
      s1_byte_r  <= in_byte;
      s1_idx_r   <= in_idx;
      s1_color_r <= in_color;
      s1_sub_r   <= 3'd0;
    end else if (fire && !step_last && is_sub) begin
      s1_byte_r <= byte_shift;
      s1_sub_r  <= s1_sub_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      col_r   <= '0;
      row_r   <= '0;
      phase_r <= '0;
      held_r  <= '0;
    end else begin
      if (fire) begin
        col_r <= row_end_now ? '0 : col_inc[CW-1:0];
        if (row_end_now) begin
          row_r <= frame_end_now ? '0 : row_inc[pfu_pkg::ROW_W-1:0];
        end
      end
      if (retire && !s1_kind_r && !is_sub && !is_idx8 && is_multi) begin
        phase_r <= ph_nxt;
        if (multi_hold) begin
          held_r <= held_nxt;
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: src/pfu_out.sv
`default_nettype none
module pfu_out (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  pfu_pkg::res_t               res_in,
  input  logic                        order,
  input  logic [pfu_pkg::COLOR_W-1:0] pal_data,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [pfu_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_last,
  output logic                        out_row_end,
  output logic                        out_frame_end,
  output logic                        free
);

  logic          valid_r;
  pfu_pkg::res_t res_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  // Palette entries are stored red in the low byte and reordered on the way out.
  assign out_pixel     = res_r.pal_sel ?
                         pfu_pkg::pack_pixel(order, pal_data[7:0], pal_data[15:8],
                                             pal_data[23:16], pal_data[31:24]) :
                         res_r.pixel;
  assign out_valid     = valid_r;
  assign out_last      = res_r.last;
  assign out_row_end   = res_r.row_end;
  assign out_frame_end = res_r.frame_end;

endmodule
`default_nettype wire

// File: src/pfu_checker.sv
`default_nettype none
`include "pixel_format_unpacker_assert.svh"
module pfu_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser
);

  // A stalled item keeps its contents until it is taken.
  `PFU_ASSERT_NEXT(a_out_hold, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser), "stalled output item changed")

  // The final pixel of a frame always closes a row.
  `PFU_ASSERT_SAME(a_frame_row, rst_n, out_tvalid && out_tuser[1], out_tuser[0], "frame end without row end")

  // A row end finishes the byte that caused it, since padding bits are dropped.
  `PFU_ASSERT_SAME(a_row_last, rst_n, out_tvalid && out_tuser[0], out_tlast, "row end item not last of its byte")

  // Reset empties the result register.
  `PFU_ASSERT_RESET(a_reset_empty, rst_n, !out_tvalid, "output valid after reset")

endmodule

bind pixel_format_unpacker pfu_checker u_pfu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  import pfu_pkg::*;

  localparam int MAX_WIDTH     = 4096;
  localparam int PALETTE_DEPTH = 256;
  localparam int SETTLE        = 8;
  localparam int RANDOM_ITEMS  = 100;
  localparam int CALM_FROM     = 80;
  localparam int CALM_TO       = 130;
  localparam int PAL_FILL      = 16;
  // Code 15 names no format; the block swallows data bytes with no pixel.
  localparam logic [FMT_W-1:0] FMT_NONE = 4'd15;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             row_end;
    logic             frame_end;
  } pixel_due_t;

  typedef enum logic [1:0] {STEP_CFG, STEP_BYTE, STEP_PAL} step_kind_t;

  typedef struct packed {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] arg;
    logic [COLOR_W-1:0]    color;
    logic                  typed;
    logic [PIX_W-1:0]      want_pixel;
    logic                  want_row_end;
    logic                  want_frame_end;
  } step_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic [1:0]            out_tuser;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  int mismatches   = 0;
  int items_sent   = 0;
  bit stream_dirty = 1'b0;
  wire calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

  // Shadow of the block's configuration and image position.
  logic [FMT_W-1:0]      fmt_r;
  logic                  order_r;
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [PAL_SIZE_W-1:0] pal_size_r;
  int                    phase_r;
  logic [23:0]           held_r;
  int                    col_r;
  int                    row_r;
  logic [COLOR_W-1:0]    palette [PALETTE_DEPTH];

  pixel_due_t fresh_pixels [$];
  pixel_due_t pixels_due [$];

  pixel_format_unpacker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic step_t set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    step_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.reg_idx = idx;
    s.arg = CFG_DATA_W'(val);
    return s;
  endfunction

  function automatic step_t feed(input logic [7:0] b);
    step_t s;
    s = '0;
    s.kind = STEP_BYTE;
    s.arg = {5'd0, b};
    return s;
  endfunction

  function automatic step_t feed_typed(input logic [7:0] b, input logic [PIX_W-1:0] pix,
                                       input logic re, input logic fe);
    step_t s;
    s = feed(b);
    s.typed = 1'b1;
    s.want_pixel = pix;
    s.want_row_end = re;
    s.want_frame_end = fe;
    return s;
  endfunction

  function automatic step_t load_entry(input logic [7:0] idx, input logic [COLOR_W-1:0] c);
    step_t s;
    s = '0;
    s.kind = STEP_PAL;
    s.arg = {5'd0, idx};
    s.color = c;
    return s;
  endfunction

  function automatic void restart_frame();
    phase_r = 0;
    held_r = '0;
    col_r = 0;
    row_r = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_FORMAT: begin
        fmt_r = val[FMT_W-1:0];
        restart_frame();
      end
      CFG_ORDER: order_r = val[0];
      CFG_WIDTH: begin
        width_r = val;
        restart_frame();
      end
      CFG_HEIGHT: begin
        height_r = val;
        restart_frame();
      end
      CFG_PAL_SIZE: pal_size_r = val[PAL_SIZE_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic int row_len();
    if (width_r == 0) return 1;
    if (width_r > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_r);
  endfunction

  function automatic int frame_rows();
    if (height_r == 0) return 1;
    if (height_r > HEIGHT_MAX) return HEIGHT_MAX;
    return int'(height_r);
  endfunction

  function automatic logic [PIX_W-1:0] arrange(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b, input logic [7:0] a);
    return order_r ? {a, r, g, b} : {a, b, g, r};
  endfunction

  function automatic logic [PIX_W-1:0] palette_pixel(input logic [7:0] idx);
    logic [COLOR_W-1:0] c;
    if (int'(idx) >= int'(pal_size_r)) return '0;
    c = palette[idx];
    return arrange(c[7:0], c[15:8], c[23:16], c[31:24]);
  endfunction

  function automatic void chan_shape(input logic [FMT_W-1:0] f, output int ch, output int st);
    case (f)
      FMT_RGB8:       begin ch = 3; st = 1; end
      FMT_RGB16:      begin ch = 3; st = 2; end
      FMT_RGBA8:      begin ch = 4; st = 1; end
      FMT_RGBA16:     begin ch = 4; st = 2; end
      FMT_LUM8:       begin ch = 1; st = 1; end
      FMT_LUM16:      begin ch = 1; st = 2; end
      FMT_LUMALPHA8:  begin ch = 2; st = 1; end
      FMT_LUMALPHA16: begin ch = 2; st = 2; end
      default:        begin ch = 0; st = 1; end
    endcase
  endfunction

  // Each pixel advances the image position and picks up the row and frame marks.
  function automatic void add_pixel(input logic [PIX_W-1:0] pix);
    pixel_due_t p;
    p = '0;
    p.pixel = pix;
    col_r++;
    if (col_r >= row_len()) begin
      col_r = 0;
      p.row_end = 1'b1;
      row_r++;
      if (row_r >= frame_rows()) begin
        row_r = 0;
        p.frame_end = 1'b1;
      end
    end
    fresh_pixels.push_back(p);
  endfunction

  function automatic void unpack_byte(input logic kind, input logic [7:0] b,
                                      input logic [7:0] idx, input logic [COLOR_W-1:0] color);
    int bpp, cnt, sample, ch, st, c;
    logic [7:0] lum;
    fresh_pixels.delete();
    if (kind) begin
      palette[idx] = color;
      return;
    end
    if ((fmt_r >= FMT_LUM1 && fmt_r <= FMT_LUM4) ||
        (fmt_r >= FMT_INDEX1 && fmt_r <= FMT_INDEX4)) begin
      bpp = (fmt_r <= FMT_LUM4) ? (1 << int'(fmt_r - FMT_LUM1))
                                : (1 << int'(fmt_r - FMT_INDEX1));
      // Samples past the end of the row are padding and yield nothing.
      cnt = 8 / bpp;
      if (row_len() - col_r < cnt) cnt = row_len() - col_r;
      for (int i = 0; i < cnt; i++) begin
        sample = (int'(b) >> (8 - bpp * (i + 1))) & ((1 << bpp) - 1);
        lum = 8'(sample * (bpp == 1 ? 255 : (bpp == 2 ? 85 : 17)));
        if (fmt_r <= FMT_LUM4) add_pixel(arrange(lum, lum, lum, 8'hFF));
        else add_pixel(palette_pixel(8'(sample)));
      end
    end else if (fmt_r == FMT_INDEX8) begin
      add_pixel(palette_pixel(b));
    end else begin
      chan_shape(fmt_r, ch, st);
      if (ch != 0) begin
        // Only the first byte of each channel counts; the pixel goes out on
        // the first byte of its final channel.
        if (phase_r % st == 0) begin
          c = phase_r / st;
          if (c + 1 < ch && c < 3) begin
            held_r[8*c +: 8] = b;
          end else if (c + 1 == ch) begin
            case (ch)
              3: add_pixel(arrange(held_r[7:0], held_r[15:8], b, 8'hFF));
              4: add_pixel(arrange(held_r[7:0], held_r[15:8], held_r[23:16], b));
              1: add_pixel(arrange(b, b, b, 8'hFF));
              default: add_pixel(arrange(held_r[7:0], held_r[7:0], held_r[7:0], b));
            endcase
          end
        end
        phase_r = (phase_r + 1 >= ch * st) ? 0 : phase_r + 1;
      end
    end
    if (fresh_pixels.size() > 0) fresh_pixels[fresh_pixels.size()-1].last = 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    // Palette writes and silent bytes may still be in the pipe.
    if (stream_dirty) repeat (SETTLE) @(posedge clk);
    stream_dirty = 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
  endtask

  task automatic push_item(input logic kind, input logic [7:0] b, input logic [7:0] idx,
                           input logic [COLOR_W-1:0] color);
    cfg_valid <= 1'b0;
    while (!calm && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {color, idx, b};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    stream_dirty = 1'b1;
    unpack_byte(kind, b, idx, color);
    foreach (fresh_pixels[k]) pixels_due.push_back(fresh_pixels[k]);
  endtask

  task automatic random_phase(input logic [FMT_W-1:0] code);
    int pick, ch, st, unit, count;
    logic [CFG_DATA_W-1:0] val;
    logic [7:0] b;
    pick = $urandom_range(0, 99);
    if (pick < 75) val = CFG_DATA_W'($urandom_range(1, 12));
    else if (pick < 85) val = CFG_DATA_W'(MAX_WIDTH);
    else if (pick < 92) val = CFG_DATA_W'($urandom_range(MAX_WIDTH + 1, 8191));
    else if (pick < 95) val = '0;
    else val = CFG_DATA_W'($urandom_range(1, 8191));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_WIDTH, val);
    pick = $urandom_range(0, 99);
    if (pick < 80) val = CFG_DATA_W'($urandom_range(1, 4));
    else if (pick < 88) val = CFG_DATA_W'(HEIGHT_MAX);
    else if (pick < 94) val = '0;
    else val = CFG_DATA_W'($urandom_range(0, 8191));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_HEIGHT, val);
    if ($urandom_range(0, 1) != 0) write_reg(CFG_ORDER, CFG_DATA_W'($urandom_range(0, 8191)));
    // Sizes stay within the filled entries; the upper data bits are dropped by the block.
    pick = $urandom_range(0, 99);
    if (pick < 55) val = CFG_DATA_W'($urandom_range(1, PAL_FILL));
    else if (pick < 70) val = CFG_DATA_W'(PAL_FILL);
    else if (pick < 80) val = '0;
    else val = {4'($urandom_range(0, 15)), 9'($urandom_range(0, PAL_FILL))};
    if ($urandom_range(0, 2) != 0) write_reg(CFG_PAL_SIZE, val);
    val = {9'd0, code};
    if ($urandom_range(0, 4) == 0) val[CFG_DATA_W-1:FMT_W] = 9'($urandom_range(0, 511));
    write_reg(CFG_FORMAT, val);

    // Mostly whole pixels; now and then a count that breaks the byte grouping.
    chan_shape(code, ch, st);
    unit = (ch == 0) ? 1 : ch * st;
    count = unit * $urandom_range(1, (12 / unit > 1) ? 12 / unit : 1);
    if ($urandom_range(0, 99) < 15) count = $urandom_range(1, 12);
    repeat (count) begin
      if ($urandom_range(0, 9) == 0)
        push_item(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), $urandom());
      pick = $urandom_range(0, 9);
      if (pick == 0) b = 8'h00;
      else if (pick == 1) b = 8'hFF;
      else b = 8'($urandom_range(0, 255));
      push_item(1'b0, b, 8'($urandom_range(0, 255)), $urandom());
    end
  endtask

  always @(posedge clk) out_tready <= calm || ($urandom_range(0, 99) >= 38);

  always @(posedge clk) begin : watch_pixels
    pixel_due_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel: expected none, got %h", out_tdata);
        mismatches++;
      end else begin
        want = pixels_due.pop_front();
        if (out_tdata !== want.pixel) begin
          $error("pixel: expected %h, got %h", want.pixel, out_tdata);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_tlast);
          mismatches++;
        end
        if (out_tuser[0] !== want.row_end) begin
          $error("row_end: expected %b, got %b", want.row_end, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, out_tuser[1]);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int codes [16];
    int j, tmp, phase_no, random_from;
    step_t plan [$];
    pixel_due_t want;
    fmt_r = FMT_RGB8;
    order_r = 1'b0;
    width_r = 13'd1;
    height_r = 13'd1;
    pal_size_r = '0;
    restart_frame();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the low entries and the top one; every lookup below stays among them.
    for (int i = 0; i < PAL_FILL; i++)
      push_item(1'b1, 8'($urandom_range(0, 255)), 8'(i), $urandom());
    push_item(1'b1, 8'($urandom_range(0, 255)), 8'(PALETTE_DEPTH - 1), $urandom());

    plan = '{
      feed(8'h00), feed(8'h80), feed_typed(8'hFF, 32'hFFFF8000, 1'b1, 1'b1),
      set_reg(CFG_ORDER, 1),
      feed(8'h00), feed(8'h80), feed_typed(8'hFF, 32'hFF0080FF, 1'b1, 1'b1),
      set_reg(CFG_HEIGHT, 8191), set_reg(CFG_WIDTH, 8191), set_reg(CFG_FORMAT, FMT_LUM1),
      feed(8'hA5), feed(8'hFF),
      set_reg(CFG_WIDTH, 0), set_reg(CFG_HEIGHT, 0), set_reg(CFG_FORMAT, FMT_LUM2),
      feed_typed(8'hC0, 32'hFFFFFFFF, 1'b1, 1'b1),
      set_reg(CFG_WIDTH, 3), set_reg(CFG_HEIGHT, 2), set_reg(CFG_FORMAT, FMT_LUM4),
      feed(8'hF0), feed(8'h1E), feed(8'h7F),
      set_reg(CFG_PAL_SIZE, PALETTE_DEPTH), set_reg(CFG_WIDTH, MAX_WIDTH),
      set_reg(CFG_HEIGHT, HEIGHT_MAX), set_reg(CFG_FORMAT, FMT_INDEX8),
      feed(8'h00), feed(8'hFF),
      set_reg(CFG_PAL_SIZE, 0), feed_typed(8'h05, 32'h00000000, 1'b0, 1'b0),
      set_reg(CFG_PAL_SIZE, 3), set_reg(CFG_WIDTH, 8), set_reg(CFG_FORMAT, FMT_INDEX1),
      feed(8'h5A),
      set_reg(CFG_FORMAT, FMT_INDEX2), feed(8'hE4),
      set_reg(CFG_PAL_SIZE, 511), set_reg(CFG_FORMAT, FMT_INDEX4), feed(8'hF0),
      load_entry(8'hFF, 32'hFFFFFFFF), load_entry(8'h00, 32'h00000000),
      set_reg(CFG_PAL_SIZE, PALETTE_DEPTH), set_reg(CFG_FORMAT, FMT_INDEX8),
      feed_typed(8'hFF, 32'hFFFFFFFF, 1'b0, 1'b0), feed(8'h00),
      set_reg(CFG_FORMAT, FMT_NONE), feed(8'h77),
      set_reg(CFG_ORDER, 0), set_reg(CFG_FORMAT, FMT_LUMALPHA16),
      feed(8'h80), feed(8'h01), feed_typed(8'hFF, 32'hFF808080, 1'b0, 1'b0), feed(8'h02)
    };

    foreach (plan[i]) begin
      case (plan[i].kind)
        STEP_CFG: write_reg(plan[i].reg_idx, plan[i].arg);
        STEP_PAL: push_item(1'b1, 8'($urandom_range(0, 255)), plan[i].arg[7:0], plan[i].color);
        default: begin
          push_item(1'b0, plan[i].arg[7:0], 8'($urandom_range(0, 255)), $urandom());
          if (plan[i].typed && fresh_pixels.size() == 1) begin
            want = '0;
            want.pixel = plan[i].want_pixel;
            want.last = 1'b1;
            want.row_end = plan[i].want_row_end;
            want.frame_end = plan[i].want_frame_end;
            pixels_due[pixels_due.size()-1] = want;
          end
        end
      endcase
    end

    // The random part starts with a palette size that covers only filled entries.
    write_reg(CFG_PAL_SIZE, CFG_DATA_W'(PAL_FILL));

    // Every format code, bad one included, gets at least one random phase.
    for (int i = 0; i < 16; i++) codes[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = codes[i];
      codes[i] = codes[j];
      codes[j] = tmp;
    end
    random_from = items_sent;
    phase_no = 0;
    while (items_sent - random_from < RANDOM_ITEMS || phase_no < 16) begin
      random_phase(FMT_W'(codes[phase_no % 16]));
      phase_no++;
    end

    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
